/* hdl/kat_pkg.sv */
package kat_pkg;

    localparam int unsigned KeyCount   = 18;
    localparam int unsigned FrameWidth = 10;
    localparam int unsigned TimeWidth  = 16;
    localparam int unsigned CodeWidth  = 4;
    localparam int unsigned CfgIdxWidth = 2;

    // key bit positions in the held mask
    localparam int unsigned KeyW      = 0;
    localparam int unsigned KeyA      = 1;
    localparam int unsigned KeyS      = 2;
    localparam int unsigned KeyD      = 3;
    localparam int unsigned KeySpace  = 4;
    localparam int unsigned KeyEnter  = 5;
    localparam int unsigned KeyBksp   = 6;
    localparam int unsigned KeyTab    = 7;
    localparam int unsigned KeyN1     = 8;
    localparam int unsigned KeyN2     = 9;
    localparam int unsigned KeyN3     = 10;
    localparam int unsigned KeyN4     = 11;
    localparam int unsigned KeyZ      = 12;
    localparam int unsigned KeyShift  = 13;
    localparam int unsigned KeyLeft   = 14;
    localparam int unsigned KeyRight  = 15;
    localparam int unsigned KeyUp     = 16;
    localparam int unsigned KeyDown   = 17;

    // action codes
    localparam logic [CodeWidth-1:0] ActUp       = 4'd0;
    localparam logic [CodeWidth-1:0] ActLeft     = 4'd1;
    localparam logic [CodeWidth-1:0] ActDown     = 4'd2;
    localparam logic [CodeWidth-1:0] ActRight    = 4'd3;
    localparam logic [CodeWidth-1:0] ActSelect   = 4'd4;
    localparam logic [CodeWidth-1:0] ActDeselect = 4'd5;
    localparam logic [CodeWidth-1:0] ActNum1     = 4'd6;
    localparam logic [CodeWidth-1:0] ActNum2     = 4'd7;
    localparam logic [CodeWidth-1:0] ActNum3     = 4'd8;
    localparam logic [CodeWidth-1:0] ActNum4     = 4'd9;
    localparam logic [CodeWidth-1:0] ActConfirm  = 4'd10;
    localparam logic [CodeWidth-1:0] ActNone     = 4'd0;

    // configuration register indexes
    localparam logic [CfgIdxWidth-1:0] CfgRepeatDelay    = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CfgRepeatInterval = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CfgConfirmCool    = 2'd2;

    // reset values of the configuration registers
    localparam logic [TimeWidth-1:0] RepeatDelayReset    = 16'd300;
    localparam logic [TimeWidth-1:0] RepeatIntervalReset = 16'd50;
    localparam logic [TimeWidth-1:0] ConfirmCoolReset    = 16'd1000;

    typedef struct packed {
        logic [KeyCount-1:0]   keys_held;
        logic [FrameWidth-1:0] frame_ms;
    } t_in_word;

    typedef struct packed {
        logic                 action_valid;
        logic [CodeWidth-1:0] action_code;
        logic                 is_undo;
    } t_out_word;

    typedef struct packed {
        logic [TimeWidth-1:0] repeat_delay_ms;
        logic [TimeWidth-1:0] repeat_interval_ms;
        logic [TimeWidth-1:0] confirm_cooldown_ms;
    } t_cfg;

endpackage

/* hdl/kat_cfg.sv */
module kat_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [kat_pkg::CfgIdxWidth-1:0]  i_cfg_index,
    input  logic [kat_pkg::TimeWidth-1:0]    i_cfg_data,
    output kat_pkg::t_cfg                    o_cfg
);
    import kat_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_delay_ms     <= RepeatDelayReset;
            r_cfg.repeat_interval_ms  <= RepeatIntervalReset;
            r_cfg.confirm_cooldown_ms <= ConfirmCoolReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgRepeatDelay:    r_cfg.repeat_delay_ms     <= i_cfg_data;
                CfgRepeatInterval: r_cfg.repeat_interval_ms  <= i_cfg_data;
                CfgConfirmCool:    r_cfg.confirm_cooldown_ms <= i_cfg_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/kat_core.sv */
module kat_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  kat_pkg::t_in_word  i_word,
    input  kat_pkg::t_cfg      i_cfg,
    output kat_pkg::t_out_word o_word
);
    import kat_pkg::*;

    logic [KeyCount-1:0]  r_prev_keys;
    logic [TimeWidth-1:0] r_timer;
    logic                 r_repeating;
    logic [TimeWidth-1:0] r_cooldown;

    logic [TimeWidth-1:0] n_timer;
    logic                 n_repeating;
    logic [TimeWidth-1:0] n_cooldown;
    t_out_word            n_word;

    always_comb begin
        logic [KeyCount-1:0]  held;
        logic [KeyCount-1:0]  press;
        logic [TimeWidth:0]   cd_diff;
        logic [TimeWidth-1:0] cd_dec;
        logic [TimeWidth:0]   t_sum;
        logic [TimeWidth-1:0] t_sat;
        logic [TimeWidth-1:0] thr;
        logic                 arrow_held;
        logic [CodeWidth-1:0] held_dir;

        held    = i_word.keys_held;
        press   = held & ~r_prev_keys;
        cd_diff = {1'b0, r_cooldown} - {{(TimeWidth+1-FrameWidth){1'b0}}, i_word.frame_ms};
        cd_dec  = cd_diff[TimeWidth] ? '0 : cd_diff[TimeWidth-1:0];

        t_sum = {1'b0, r_timer} + {{(TimeWidth+1-FrameWidth){1'b0}}, i_word.frame_ms};
        t_sat = t_sum[TimeWidth] ? '1 : t_sum[TimeWidth-1:0];
        thr   = r_repeating ? i_cfg.repeat_interval_ms : i_cfg.repeat_delay_ms;

        arrow_held = held[KeyLeft] | held[KeyRight] | held[KeyUp] | held[KeyDown];
        if (held[KeyLeft])       held_dir = ActLeft;
        else if (held[KeyRight]) held_dir = ActRight;
        else if (held[KeyUp])    held_dir = ActUp;
        else                     held_dir = ActDown;

        n_timer     = r_timer;
        n_repeating = r_repeating;
        n_cooldown  = cd_dec;
        n_word      = '{action_valid: 1'b1, action_code: ActNone, is_undo: 1'b0};

        if (press[KeyW]) begin
            n_word.action_code = ActUp;
        end else if (press[KeyA]) begin
            n_word.action_code = ActLeft;
        end else if (press[KeyS]) begin
            n_word.action_code = ActDown;
        end else if (press[KeyD]) begin
            n_word.action_code = ActRight;
        end else if (press[KeySpace] | press[KeyEnter]) begin
            n_word.action_code = ActSelect;
        end else if (press[KeyBksp] | press[KeyTab]) begin
            n_word.action_code = ActDeselect;
        end else if (press[KeyN1]) begin
            n_word.action_code = ActNum1;
        end else if (press[KeyN2]) begin
            n_word.action_code = ActNum2;
        end else if (press[KeyN3]) begin
            n_word.action_code = ActNum3;
        end else if (press[KeyN4]) begin
            n_word.action_code = ActNum4;
        end else if (press[KeyZ]) begin
            n_word.is_undo = 1'b1;
        end else if (press[KeyShift] && (cd_dec == '0)) begin
            n_cooldown         = i_cfg.confirm_cooldown_ms;
            n_word.action_code = ActConfirm;
        end else if (press[KeyLeft] | press[KeyRight] | press[KeyUp] | press[KeyDown]) begin
            n_timer     = '0;
            n_repeating = 1'b0;
            if (press[KeyLeft])       n_word.action_code = ActLeft;
            else if (press[KeyRight]) n_word.action_code = ActRight;
            else if (press[KeyUp])    n_word.action_code = ActUp;
            else                      n_word.action_code = ActDown;
        end else if (arrow_held) begin
            if (t_sat >= thr) begin
                n_timer            = '0;
                n_repeating        = 1'b1;
                n_word.action_code = held_dir;
            end else begin
                n_timer             = t_sat;
                n_word.action_valid = 1'b0;
            end
        end else begin
            n_timer             = '0;
            n_repeating         = 1'b0;
            n_word.action_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_keys <= '0;
            r_timer     <= '0;
            r_repeating <= 1'b0;
            r_cooldown  <= '0;
        end else if (i_en) begin
            r_prev_keys <= i_word.keys_held;
            r_timer     <= n_timer;
            r_repeating <= n_repeating;
            r_cooldown  <= n_cooldown;
        end
    end

    assign o_word = n_word;

endmodule

/* hdl/key_action_typematic_repeat.sv */
// Flow: a word accepted into the input register is decoded by the core and moves on
//   to the output register when that slot is free or being drained; o_valid then rises.
// Throughput: one word per cycle without sink stalls; decode is one pass of compare/add.
// Reset (i_rst_n low, synchronous): pipeline empties, key history, repeat timer and
//   confirm cooldown clear, config registers return to 300 / 50 / 1000 ms.
module key_action_typematic_repeat (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  kat_pkg::t_in_word                i_data,
    // output channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output kat_pkg::t_out_word               o_data,
    // config write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kat_pkg::CfgIdxWidth-1:0]  i_cfg_index,
    input  logic [kat_pkg::TimeWidth-1:0]    i_cfg_data
);
    import kat_pkg::*;

    // Input register: holds the accepted word while the core decodes it.
    logic      r_in_vld;
    t_in_word  r_in;
    // Output register: decoded word waiting for the sink.
    logic      r_out_vld;
    t_out_word r_out;

    t_cfg      cfg;
    t_out_word dec_word;
    logic      advance;

    // The word in the input register moves on when the output slot is free or
    // is being drained this cycle; core state commits exactly then.
    assign advance = r_in_vld & (~r_out_vld | ~i_stall);
    assign o_stall = r_in_vld & ~advance;

    // Config always writable; software must only write while the block is idle (unchecked).
    assign o_cfg_ready = 1'b1;

    kat_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    kat_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_word  (r_in),
        .i_cfg   (cfg),
        .o_word  (dec_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // input side: load on accept, empty when moved on with nothing new
            if (i_valid & ~o_stall) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            // output side: fill from the core, empty when the sink takes it
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (~i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_valid & ~o_stall) begin
            r_in <= i_data;
        end
        if (advance) begin
            r_out <= dec_word;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

/* dv/kat_checker.sv */
`timescale 1ns / 100ps

module kat_checker
    import kat_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_in_stall,
    input  t_in_word               i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  t_out_word              i_out_data,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CfgIdxWidth-1:0] i_cfg_index,
    input  logic [TimeWidth-1:0]   i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef logic [KeyCount-1:0] t_keys;

    t_cfg                 cfg_shadow;
    t_keys                last_keys;
    logic [TimeWidth-1:0] hold_timer;
    logic                 in_repeat;
    logic [TimeWidth-1:0] confirm_lock;
    t_out_word            expected_actions[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_out_word action_of(input logic [CodeWidth-1:0] code);
        return '{action_valid: 1'b1, action_code: code, is_undo: 1'b0};
    endfunction

    // first arrow in the order left, right, up, down; all zero if none
    function automatic t_out_word arrow_action(input t_keys m);
        if (m[KeyLeft])  return action_of(ActLeft);
        if (m[KeyRight]) return action_of(ActRight);
        if (m[KeyUp])    return action_of(ActUp);
        if (m[KeyDown])  return action_of(ActDown);
        return '0;
    endfunction

    function automatic t_out_word decode_frame(input t_in_word w);
        t_keys                press;
        t_out_word            res;
        t_out_word            press_arrow;
        t_out_word            held_arrow;
        logic [TimeWidth:0]   sum;
        logic [TimeWidth-1:0] thr;
        press       = w.keys_held & ~last_keys;
        last_keys   = w.keys_held;
        press_arrow = arrow_action(press);
        held_arrow  = arrow_action(w.keys_held);
        res         = '0;
        if (confirm_lock > TimeWidth'(w.frame_ms)) begin
            confirm_lock = confirm_lock - TimeWidth'(w.frame_ms);
        end else begin
            confirm_lock = '0;
        end
        if (press[KeyW]) begin
            res = action_of(ActUp);
        end else if (press[KeyA]) begin
            res = action_of(ActLeft);
        end else if (press[KeyS]) begin
            res = action_of(ActDown);
        end else if (press[KeyD]) begin
            res = action_of(ActRight);
        end else if (press[KeySpace] || press[KeyEnter]) begin
            res = action_of(ActSelect);
        end else if (press[KeyBksp] || press[KeyTab]) begin
            res = action_of(ActDeselect);
        end else if (press[KeyN1]) begin
            res = action_of(ActNum1);
        end else if (press[KeyN2]) begin
            res = action_of(ActNum2);
        end else if (press[KeyN3]) begin
            res = action_of(ActNum3);
        end else if (press[KeyN4]) begin
            res = action_of(ActNum4);
        end else if (press[KeyZ]) begin
            res = '{action_valid: 1'b1, action_code: ActNone, is_undo: 1'b1};
        end else if (press[KeyShift] && confirm_lock == '0) begin
            confirm_lock = cfg_shadow.confirm_cooldown_ms;
            res          = action_of(ActConfirm);
        end else if (press_arrow.action_valid) begin
            hold_timer = '0;
            in_repeat  = 1'b0;
            res        = press_arrow;
        end else if (held_arrow.action_valid) begin
            thr = in_repeat ? cfg_shadow.repeat_interval_ms : cfg_shadow.repeat_delay_ms;
            sum = {1'b0, hold_timer} + (TimeWidth + 1)'(w.frame_ms);
            hold_timer = sum[TimeWidth] ? '1 : sum[TimeWidth-1:0];
            if (hold_timer >= thr) begin
                hold_timer = '0;
                in_repeat  = 1'b1;
                res        = held_arrow;
            end
        end else begin
            hold_timer = '0;
            in_repeat  = 1'b0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (!i_rst_n) begin
            cfg_shadow.repeat_delay_ms     = RepeatDelayReset;
            cfg_shadow.repeat_interval_ms  = RepeatIntervalReset;
            cfg_shadow.confirm_cooldown_ms = ConfirmCoolReset;
            last_keys    = '0;
            hold_timer   = '0;
            in_repeat    = 1'b0;
            confirm_lock = '0;
            expected_actions.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CfgRepeatDelay:    cfg_shadow.repeat_delay_ms     = i_cfg_data;
                    CfgRepeatInterval: cfg_shadow.repeat_interval_ms  = i_cfg_data;
                    CfgConfirmCool:    cfg_shadow.confirm_cooldown_ms = i_cfg_data;
                    default: ;
                endcase
            end
            // drain the output before taking the new word
            if (i_out_valid && !i_out_stall) begin
                if (expected_actions.size() == 0) begin
                    $display("%0t: unexpected word: valid=%0b code=%0d undo=%0b", $time,
                             i_out_data.action_valid, i_out_data.action_code,
                             i_out_data.is_undo);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_word = expected_actions.pop_front();
                    if (i_out_data.action_valid !== exp_word.action_valid ||
                        i_out_data.action_code  !== exp_word.action_code  ||
                        i_out_data.is_undo      !== exp_word.is_undo) begin
                        $display("%0t: mismatch: expected valid=%0b code=%0d undo=%0b, got valid=%0b code=%0d undo=%0b",
                                 $time, exp_word.action_valid, exp_word.action_code,
                                 exp_word.is_undo, i_out_data.action_valid,
                                 i_out_data.action_code, i_out_data.is_undo);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_valid && !i_in_stall) begin
                expected_actions.push_back(decode_frame(i_in_data));
            end
        end
        o_pending = expected_actions.size();
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import kat_pkg::*;

    typedef logic [KeyCount-1:0] t_keys;

    // index past the last register; the block must ignore writes to it
    localparam logic [CfgIdxWidth-1:0] CfgUnused = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    t_in_word               i_data;
    logic                   o_valid;
    logic                   i_stall;
    t_out_word              o_data;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CfgIdxWidth-1:0] i_cfg_index;
    logic [TimeWidth-1:0]   i_cfg_data;

    int    fail_count;
    int    pending;
    t_keys cur_keys;      // held mask that the random part walks
    bit    burst_mode;    // sender offers back to back when set
    int    hold_req;      // bumped by the sender to ask for a long receiver hold-off
    int    hold_seen;

    key_action_typematic_repeat i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    kat_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit, far above the slowest legal run
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_keys key(input int unsigned pos);
        return t_keys'(1) << pos;
    endfunction

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    // frame time: mostly short frames, edges of the range now and then
    function automatic logic [FrameWidth-1:0] pick_frame();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return '0;
        if (r < 10) return '1;
        if (r < 65) return FrameWidth'($urandom_range(0, 40));
        if (r < 90) return FrameWidth'($urandom_range(0, 250));
        return FrameWidth'($urandom_range(0, 1023));
    endfunction

    // receiver side: runs of free cycles, stalls mostly short, few long
    initial begin
        int run;
        int st;
        int r;
        i_stall   = 1'b0;
        hold_seen = 0;
        forever begin
            if (hold_req != hold_seen) begin
                // long hold-off: block fills and must stall the sender
                i_stall <= 1'b1;
                repeat (150) @(negedge i_clk);
                hold_seen = hold_seen + 1;
            end else begin
                r   = $urandom_range(0, 99);
                run = (r < 80) ? $urandom_range(1, 8) : $urandom_range(20, 100);
                i_stall <= 1'b0;
                repeat (run) @(negedge i_clk);
                r = $urandom_range(0, 99);
                if (r < 55)      st = 0;
                else if (r < 88) st = $urandom_range(1, 3);
                else if (r < 97) st = $urandom_range(4, 10);
                else             st = $urandom_range(15, 40);
                if (st > 0) begin
                    i_stall <= 1'b1;
                    repeat (st) @(negedge i_clk);
                end
            end
        end
    end

    // offer one word, called at a falling edge, returns at a falling edge
    task automatic send_frame(input t_keys k, input logic [FrameWidth-1:0] f);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{keys_held: k, frame_ms: f};
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // sender pauses until every expected word is back
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                             input logic [TimeWidth-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [TimeWidth-1:0] delay,
                              input logic [TimeWidth-1:0] interval,
                              input logic [TimeWidth-1:0] cool);
        drain();
        write_reg(CfgRepeatDelay, delay);
        write_reg(CfgRepeatInterval, interval);
        write_reg(CfgConfirmCool, cool);
        i_cfg_valid <= 1'b0;
    endtask

    // hold a random set of arrows for n frames, other keys unchanged
    task automatic hold_arrows(input int n, input int fmin, input int fmax);
        cur_keys[KeyDown:KeyLeft] = 4'($urandom_range(1, 15));
        for (int i = 0; i < n; i++) begin
            send_frame(cur_keys, FrameWidth'($urandom_range(fmin, fmax)));
        end
    endtask

    // random walk over the held mask; arrows and shift get extra weight
    task automatic random_frames(input int count);
        int r;
        int b;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain();
            r = $urandom_range(0, 99);
            if (r < 45) begin
                b = ($urandom_range(0, 1) == 1) ? $urandom_range(KeyShift, KeyDown)
                                                : $urandom_range(0, KeyCount - 1);
                cur_keys[b] = ~cur_keys[b];
            end else if (r < 70) begin
                // keep the mask: held arrows run the repeat timer
            end else if (r < 80) begin
                cur_keys = '0;
            end else if (r < 90) begin
                cur_keys = t_keys'($urandom);
            end else begin
                cur_keys = key($urandom_range(KeyLeft, KeyDown));
            end
            send_frame(cur_keys, pick_frame());
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CfgRepeatDelay;
        i_cfg_data  = '0;
        cur_keys    = '0;
        burst_mode  = 1'b0;
        hold_req    = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, reset config 300 / 50 / 1000
        send_frame('0, '0);
        send_frame(key(KeyW), 10'd16);
        send_frame(key(KeyW) | key(KeyA), 10'd16);               // A edge, W held
        send_frame('0, 10'd16);
        send_frame(key(KeyS) | key(KeyD), 10'd16);               // S wins over D
        send_frame(key(KeyD) | key(KeySpace), 10'd16);           // select by space
        send_frame(key(KeyEnter), 10'd16);                       // select by enter
        send_frame(key(KeyBksp) | key(KeyTab), 10'd16);          // deselect
        send_frame(key(KeyTab) | key(KeyN1), 10'd16);
        send_frame(key(KeyN2) | key(KeyN3) | key(KeyN4), 10'd16);
        send_frame(key(KeyN3) | key(KeyN4) | key(KeyZ), 10'd16); // undo
        send_frame(key(KeyShift) | key(KeyZ), 10'd0);            // confirm, lock loads
        send_frame('0, 10'd500);
        send_frame(key(KeyShift) | key(KeyLeft), 10'd400);       // shift locked out, left
        send_frame(key(KeyShift) | key(KeyLeft), 10'd100);       // held, below delay
        send_frame(key(KeyLeft), 10'd150);
        send_frame(key(KeyLeft), 10'd50);                        // first repeat at delay
        send_frame(key(KeyLeft) | key(KeyRight), 10'd10);        // right edge clears timer
        send_frame(key(KeyLeft) | key(KeyRight), 10'd49);
        send_frame(key(KeyLeft) | key(KeyRight), 10'd1023);      // repeat, left first
        send_frame(key(KeyLeft) | key(KeyRight) | key(KeyShift), 10'd60);
        send_frame(key(KeyLeft) | key(KeyRight) | key(KeyShift) | key(KeyW), 10'd10);
        send_frame(key(KeyRight) | key(KeyUp) | key(KeyDown) | key(KeyShift) | key(KeyW),
                   10'd50);                                      // up and down edges
        send_frame(key(KeyDown), 10'd1023);
        send_frame('1, 10'd1023);                                // every key at once
        send_frame('0, '0);
        cur_keys = '0;

        // zero thresholds: held arrows repeat every frame, shift always confirms
        set_config('0, '0, '0);
        hold_arrows(20, 0, 5);
        random_frames(120);

        // top of range: timer has to saturate to reach the delay
        set_config('1, '1, '1);
        hold_arrows(70, 1000, 1023);
        random_frames(110);

        // random setting, plus a write to the unused index
        set_config(TimeWidth'($urandom_range(0, 65535)), TimeWidth'($urandom_range(0, 65535)),
                   TimeWidth'($urandom_range(0, 65535)));
        @(negedge i_clk);
        write_reg(CfgUnused, TimeWidth'($urandom));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        hold_req <= hold_req + 1;
        random_frames(100);

        // short thresholds, sender never idles
        set_config(TimeWidth'($urandom_range(0, 100)), TimeWidth'($urandom_range(0, 100)),
                   TimeWidth'($urandom_range(0, 100)));
        burst_mode = 1'b1;
        hold_arrows(15, 0, 40);
        random_frames(100);
        burst_mode = 1'b0;

        // back to the reset values, written explicitly
        set_config(RepeatDelayReset, RepeatIntervalReset, ConfirmCoolReset);
        random_frames(100);

        set_config(TimeWidth'($urandom_range(0, 65535)), TimeWidth'($urandom_range(0, 2000)),
                   TimeWidth'($urandom_range(0, 65535)));
        hold_req <= hold_req + 1;
        random_frames(100);

        // wait out the tail; the run limit bounds this
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
